FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the filter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define SKF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define SKF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg
// Types and constants of the scalar Kalman filter.
// ----------------------------------------------------------------------------
package skf_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;               // estimate / measurement
   localparam int COV_W     = 31;               // covariance and noise values
   localparam int GAIN_W    = 17;               // gain field on the result
   localparam int QUO_W     = FRAC_BITS + 1;    // gain in [0, 1.0]
   localparam int CNT_W     = $clog2(QUO_W);
   localparam int DIFF_W    = DATA_W + 1;
   localparam int MUL_A_W   = DIFF_W + 1;
   localparam int MUL_B_W   = QUO_W + 1;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int ADDR_W    = 4;
   localparam int CSR_W     = 32;
   localparam int REQ_W     = 32;
   localparam int RSP_W     = 56;

   localparam logic [QUO_W-1:0] ONE_FX = QUO_W'(1) << FRAC_BITS;

   localparam logic [COV_W-1:0]         RST_PROCESS_NOISE      = COV_W'(655);
   localparam logic [COV_W-1:0]         RST_MEASUREMENT_NOISE  = COV_W'(65536);
   localparam logic signed [DATA_W-1:0] RST_INITIAL_ESTIMATE   = '0;
   localparam logic [COV_W-1:0]         RST_INITIAL_COVARIANCE = COV_W'(65536);

   typedef enum logic [1:0] {
      REG_PROCESS_NOISE,
      REG_MEASUREMENT_NOISE,
      REG_INITIAL_ESTIMATE,
      REG_INITIAL_COVARIANCE
   } reg_idx_type;

   typedef struct packed {
      logic [COV_W-1:0] process_noise;
      logic [COV_W-1:0] measurement_noise;
   } noise_cfg_type;

   typedef struct packed {
      logic                     load_estimate;
      logic                     load_covariance;
      logic signed [DATA_W-1:0] estimate;
      logic [COV_W-1:0]         covariance;
   } state_load_type;

   typedef struct packed {
      logic              start;
      logic [COV_W-1:0]  dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] estimate;
      logic [QUO_W-1:0]         gain;
   } result_type;

endpackage

FILE: rtl/skf_csr.sv
// ----------------------------------------------------------------------------
// skf_csr
// APB register file: noise variances and initial state values.
// ----------------------------------------------------------------------------
module skf_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [skf_pkg::ADDR_W-1:0]        csr_paddr,
   input  logic [skf_pkg::CSR_W-1:0]         csr_pwdata,
   output logic [skf_pkg::CSR_W-1:0]         csr_prdata,
   output logic                              csr_pready,
   output skf_pkg::noise_cfg_type            noise_cfg,
   output skf_pkg::state_load_type           state_load
);

   logic [skf_pkg::COV_W-1:0]         q_ff, q_in;
   logic [skf_pkg::COV_W-1:0]         r_ff, r_in;
   logic signed [skf_pkg::DATA_W-1:0] x0_ff, x0_in;
   logic [skf_pkg::COV_W-1:0]         p0_ff, p0_in;
   logic                              wr_en;
   skf_pkg::reg_idx_type              idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign idx        = skf_pkg::reg_idx_type'(csr_paddr[3:2]);

   always_comb begin
      q_in  = q_ff;
      r_in  = r_ff;
      x0_in = x0_ff;
      p0_in = p0_ff;
      if (wr_en) begin
         unique case (idx)
            skf_pkg::REG_PROCESS_NOISE:      q_in  = csr_pwdata[skf_pkg::COV_W-1:0];
            skf_pkg::REG_MEASUREMENT_NOISE:  r_in  = csr_pwdata[skf_pkg::COV_W-1:0];
            skf_pkg::REG_INITIAL_ESTIMATE:   x0_in = csr_pwdata;
            skf_pkg::REG_INITIAL_COVARIANCE: p0_in = csr_pwdata[skf_pkg::COV_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff  <= skf_pkg::RST_PROCESS_NOISE;
         r_ff  <= skf_pkg::RST_MEASUREMENT_NOISE;
         x0_ff <= skf_pkg::RST_INITIAL_ESTIMATE;
         p0_ff <= skf_pkg::RST_INITIAL_COVARIANCE;
      end else begin
         q_ff  <= q_in;
         r_ff  <= r_in;
         x0_ff <= x0_in;
         p0_ff <= p0_in;
      end
   end

   always_comb begin
      unique case (idx)
         skf_pkg::REG_PROCESS_NOISE:      csr_prdata = {1'b0, q_ff};
         skf_pkg::REG_MEASUREMENT_NOISE:  csr_prdata = {1'b0, r_ff};
         skf_pkg::REG_INITIAL_ESTIMATE:   csr_prdata = x0_ff;
         skf_pkg::REG_INITIAL_COVARIANCE: csr_prdata = {1'b0, p0_ff};
         default:                         csr_prdata = '0;
      endcase
   end

   assign noise_cfg.process_noise     = q_ff;
   assign noise_cfg.measurement_noise = r_ff;

   // State loads follow the register writes directly.
   assign state_load.load_estimate   = wr_en && (idx == skf_pkg::REG_INITIAL_ESTIMATE);
   assign state_load.load_covariance = wr_en && (idx == skf_pkg::REG_INITIAL_COVARIANCE);
   assign state_load.estimate        = csr_pwdata;
   assign state_load.covariance      = csr_pwdata[skf_pkg::COV_W-1:0];

endmodule

FILE: rtl/skf_div.sv
// ----------------------------------------------------------------------------
// skf_div
// Restoring divider, one quotient bit per cycle: floor((p << FRAC) / den).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module skf_div (
   input  logic                 clock,
   input  logic                 reset,
   input  skf_pkg::div_req_type div_req,
   output skf_pkg::div_rsp_type div_rsp
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [skf_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   logic [skf_pkg::DATA_W:0]          rem_ff, rem_in;
   logic [skf_pkg::DATA_W-1:0]        den_ff, den_in;
   logic [skf_pkg::QUO_W-1:0]         quo_ff, quo_in;
   logic                              ge;
   logic [skf_pkg::DATA_W:0]          rem_sub;
   logic [skf_pkg::DATA_W:0]          rem_sel;

   assign ge      = rem_ff >= {1'b0, den_ff};
   assign rem_sub = rem_ff - {1'b0, den_ff};
   assign rem_sel = ge ? rem_sub : rem_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         rem_in = {2'b00, div_req.dividend};
         den_in = div_req.divisor;
         cnt_in = skf_pkg::CNT_W'(skf_pkg::QUO_W - 1);
         quo_in = '0;
         if (div_req.divisor == '0) begin
            // zero denominator: gain is zero
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         // remainder stays below den, so the shift fits
         rem_in = {rem_sel[skf_pkg::DATA_W-1:0], 1'b0};
         quo_in = {quo_ff[skf_pkg::QUO_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   `SKF_ASSERT(a_div_done_single, clock, reset, div_rsp.done |=> !div_rsp.done, "divider done held")

endmodule

FILE: rtl/skf_core.sv
// ----------------------------------------------------------------------------
// skf_core
// Filter state, sequencer and shared multiplier; gain from the divider.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module skf_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic signed [skf_pkg::DATA_W-1:0] in_measurement,
   input  skf_pkg::noise_cfg_type            noise_cfg,
   input  skf_pkg::state_load_type           state_load,
   output skf_pkg::div_req_type              div_req,
   input  skf_pkg::div_rsp_type              div_rsp,
   output skf_pkg::result_type               result,
   input  logic                              result_free
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIVIDE,
      ST_MUL_EST,
      ST_MUL_COV,
      ST_WRITE,
      ST_DONE
   } state_type;

   localparam logic signed [skf_pkg::PROD_W-1:0] SUM_MAX =
      {{(skf_pkg::PROD_W-skf_pkg::DATA_W+1){1'b0}}, {(skf_pkg::DATA_W-1){1'b1}}};
   localparam logic signed [skf_pkg::PROD_W-1:0] SUM_MIN =
      {{(skf_pkg::PROD_W-skf_pkg::DATA_W+1){1'b1}}, {(skf_pkg::DATA_W-1){1'b0}}};

   state_type                          state_ff, state_in;
   logic signed [skf_pkg::DATA_W-1:0]  est_ff, est_in;
   logic [skf_pkg::COV_W-1:0]          cov_ff, cov_in;
   logic signed [skf_pkg::DATA_W-1:0]  z_ff, z_in;
   logic [skf_pkg::COV_W-1:0]          p_ff, p_in;
   logic [skf_pkg::QUO_W-1:0]          gain_ff, gain_in;
   logic signed [skf_pkg::PROD_W-1:0]  prod_ff, prod_in;

   logic [skf_pkg::DATA_W-1:0]         p_sum;
   logic [skf_pkg::COV_W-1:0]          p_sat;
   logic signed [skf_pkg::DIFF_W-1:0]  diff;
   logic signed [skf_pkg::MUL_A_W-1:0] mul_a;
   logic signed [skf_pkg::MUL_B_W-1:0] mul_b;
   logic signed [skf_pkg::PROD_W-1:0]  mul_p;
   logic signed [skf_pkg::PROD_W-1:0]  corr;
   logic signed [skf_pkg::PROD_W-1:0]  est_sum;
   logic signed [skf_pkg::DATA_W-1:0]  est_sat;

   // p + q, saturated to 31 bits
   assign p_sum = {1'b0, cov_ff} + {1'b0, noise_cfg.process_noise};
   assign p_sat = p_sum[skf_pkg::DATA_W-1] ? '1 : p_sum[skf_pkg::COV_W-1:0];

   assign div_req.start    = (state_ff == ST_SUM);
   assign div_req.dividend = p_sat;
   assign div_req.divisor  = {1'b0, p_sat} + {1'b0, noise_cfg.measurement_noise};

   assign diff = skf_pkg::DIFF_W'(z_ff) - skf_pkg::DIFF_W'(est_ff);

   // Shared multiplier: k*(z-x) first, then p*(1-k).
   always_comb begin
      if (state_ff == ST_MUL_COV) begin
         mul_a = skf_pkg::MUL_A_W'({1'b0, p_ff});
         mul_b = skf_pkg::MUL_B_W'({1'b0, skf_pkg::ONE_FX - gain_ff});
      end else begin
         mul_a = skf_pkg::MUL_A_W'(diff);
         mul_b = skf_pkg::MUL_B_W'({1'b0, gain_ff});
      end
   end

   assign mul_p = mul_a * mul_b;

   // arithmetic shift rounds toward minus infinity
   assign corr    = prod_ff >>> skf_pkg::FRAC_BITS;
   assign est_sum = skf_pkg::PROD_W'(est_ff) + corr;

   always_comb begin
      if (est_sum > SUM_MAX) begin
         est_sat = SUM_MAX[skf_pkg::DATA_W-1:0];
      end else if (est_sum < SUM_MIN) begin
         est_sat = SUM_MIN[skf_pkg::DATA_W-1:0];
      end else begin
         est_sat = est_sum[skf_pkg::DATA_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      est_in   = est_ff;
      cov_in   = cov_ff;
      z_in     = z_ff;
      p_in     = p_ff;
      gain_in  = gain_ff;
      prod_in  = prod_ff;

      if (state_load.load_estimate) begin
         est_in = state_load.estimate;
      end
      if (state_load.load_covariance) begin
         cov_in = state_load.covariance;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               z_in     = in_measurement;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            p_in     = p_sat;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               gain_in  = div_rsp.quotient;
               state_in = ST_MUL_EST;
            end
         end
         ST_MUL_EST: begin
            prod_in  = mul_p;
            state_in = ST_MUL_COV;
         end
         ST_MUL_COV: begin
            est_in   = est_sat;
            prod_in  = mul_p;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            // product is at most p << FRAC, so it fits in 31 bits
            cov_in   = prod_ff[skf_pkg::FRAC_BITS +: skf_pkg::COV_W];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (result_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         est_ff   <= skf_pkg::RST_INITIAL_ESTIMATE;
         cov_ff   <= skf_pkg::RST_INITIAL_COVARIANCE;
      end else begin
         state_ff <= state_in;
         est_ff   <= est_in;
         cov_ff   <= cov_in;
      end
      z_ff    <= z_in;
      p_ff    <= p_in;
      gain_ff <= gain_in;
      prod_ff <= prod_in;
   end

   assign in_ready        = (state_ff == ST_IDLE);
   assign result.valid    = (state_ff == ST_DONE);
   assign result.estimate = est_ff;
   assign result.gain     = gain_ff;

   `SKF_ASSERT(a_accept_starts, clock, reset, (in_valid && in_ready) |=> (state_ff == ST_SUM), "transfer did not start a step")
   `SKF_ASSERT(a_gain_le_one, clock, reset, (state_ff == ST_MUL_EST) |-> (gain_ff <= skf_pkg::ONE_FX), "gain above one")
   `SKF_ASSERT(a_cov_shrinks, clock, reset, (state_ff == ST_WRITE) |=> (cov_ff <= $past(p_ff)), "covariance grew in update")

endmodule

FILE: rtl/scalar_kalman_filter.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter
// One item is processed at a time: from the input transfer through the 17-step restoring
// divider to rsp_tvalid; a zero denominator gives a zero gain without the divider steps.
// A new item is taken while a finished result still waits in the output register.
// Reset (synchronous, active high) loads the register reset values and the state
// estimate 0 and covariance 1.0; a write of an initial value reloads that state.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scalar_kalman_filter (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [skf_pkg::REQ_W-1:0]  req_tdata,    // [31:0] measurement
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [skf_pkg::RSP_W-1:0]  rsp_tdata,    // [31:0] estimate, [48:32] gain
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [skf_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [skf_pkg::CSR_W-1:0]  csr_pwdata,
   output logic [skf_pkg::CSR_W-1:0]  csr_prdata,
   output logic                       csr_pready
);

   skf_pkg::noise_cfg_type  noise_cfg;
   skf_pkg::state_load_type state_load;
   skf_pkg::div_req_type    div_req;
   skf_pkg::div_rsp_type    div_rsp;
   skf_pkg::result_type     result;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [skf_pkg::RSP_W-1:0]        rsp_data_ff, rsp_data_in;
   logic                             slot_free;

   skf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .noise_cfg   (noise_cfg),
      .state_load  (state_load)
   );

   skf_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   skf_core u_core (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .in_measurement (req_tdata),
      .noise_cfg      (noise_cfg),
      .state_load     (state_load),
      .div_req        (div_req),
      .div_rsp        (div_rsp),
      .result         (result),
      .result_free    (slot_free)
   );

   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (result.valid && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{(skf_pkg::RSP_W-skf_pkg::DATA_W-skf_pkg::GAIN_W){1'b0}},
                         skf_pkg::GAIN_W'(result.gain), result.estimate};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `SKF_ASSERT_ALWAYS(a_reset_no_rsp, clock, reset |=> !rsp_tvalid, "result valid after reset")

endmodule
